@@ design/jsir_pkg.sv @@
// Shared types, widths and constants for the jog send-interval regulator.
package jsir_pkg;

    // Error history depth (1..64)
    localparam int HISTORY_DEPTH = 8;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

    localparam int POS_W   = 24;
    localparam int MAG_W   = 24;
    localparam int SEG_W   = 16;
    localparam int IVL_W   = 8;
    localparam int CFG_W   = 16;

    // Serial multiplier operand and product widths
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MUL_CNT_W  = $clog2(MUL_W + 1);

    // Squared distance and its root
    localparam int D2_W       = 50;
    localparam int ROOT_W     = D2_W / 2;
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

    // Error path
    localparam int T_W    = 2 * SEG_W + 2;
    localparam int ERR_W  = 36;
    localparam int SUM_W  = ERR_W + $clog2(HISTORY_DEPTH) + 1;
    localparam int SUM5_W = SUM_W + 3;
    localparam int CS_W   = FILL_W + SEG_W;

    localparam logic [IVL_W-1:0] IVL_MIN   = IVL_W'(20);
    localparam logic [IVL_W-1:0] IVL_MAX   = IVL_W'(200);
    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(80);
    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(102);

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef enum logic {
        REG_SEGMENT_DISTANCE = 1'b0,
        REG_INITIAL_INTERVAL = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [SEG_W-1:0]        sent_count;
    } item_t;

    typedef struct packed {
        logic [IVL_W-1:0] send_interval;
        logic             interval_changed;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ADD1,
        ST_ADD2,
        ST_ROOT,
        ST_SQRT,
        ST_ERR1,
        ST_ERR2,
        ST_HIST1,
        ST_HIST2,
        ST_SCALE,
        ST_CMP,
        ST_DEC,
        ST_DONE
    } state_t;

endpackage

@@ design/jsir_mul.sv @@
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module jsir_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [jsir_pkg::MUL_W-1:0] a,
    input  logic [jsir_pkg::MUL_W-1:0] b,
    output logic                       done,
    output logic [jsir_pkg::PROD_W-1:0] prod
);
    import jsir_pkg::*;

    logic [MUL_W-1:0]     hi_reg, hi_next;
    logic [MUL_W-1:0]     lo_reg, lo_next;
    logic [MUL_W-1:0]     mcand_reg, mcand_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [MUL_W:0]       acc;

    always_comb
    begin
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        acc        = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        if (start)
        begin
            hi_next    = '0;
            lo_next    = b;
            mcand_next = a;
            cnt_next   = MUL_CNT_W'(MUL_W);
            done_next  = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            hi_next  = acc[MUL_W:1];
            lo_next  = {acc[0], lo_reg[MUL_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

@@ design/jsir_sqrt.sv @@
// Digit-by-digit floor square root, one root bit per cycle.
module jsir_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [jsir_pkg::D2_W-1:0]   rad,
    output logic                        done,
    output logic [jsir_pkg::ROOT_W-1:0] root
);
    import jsir_pkg::*;

    logic [D2_W-1:0]       rad_reg, rad_next;
    logic [ROOT_W+1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [ROOT_W+1:0]     rem_sh;
    logic [ROOT_W+1:0]     trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        // remainder stays below 2^ROOT_W before the final shift
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[D2_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (start)
        begin
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = SQRT_CNT_W'(ROOT_W);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            rad_next = {rad_reg[D2_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SQRT_CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ design/jog_send_interval_regulator.sv @@
// Top level of the jog send-interval regulator: control sequencer and error history.
//
// One item is worked on at a time. A start item (kind 0) latches the position
// as the start point, empties the error history and loads initial_interval,
// clamped to 20..200. Its result is registered in ST_DONE, after which the
// block returns to idle and can take the next item. An update item (kind 1)
// is also finished in ST_DONE and then returns to idle. Before that, four
// bit-serial multipliers run side by side. They square the three axis
// distances and form sent_count*segment_distance. The squared distance is
// summed, and its floor square root is taken one bit a cycle. The remaining
// states sequence the steps. They form the error in half units, update the
// running sum of the last HISTORY_DEPTH errors, and apply the deadband
// tests: avg beyond +-seg/10 moves the interval by 1, and beyond +-seg by a
// further 2, clamped to 20..200. Each item yields one result item holding
// the new interval and whether it changed. The result sits in an output
// register, so the next item is accepted while it waits to be taken. Only a
// finished item that finds the output register still full stalls, until the
// receiver takes the waiting result. Distances are in 1/1024 mm.
// Configuration is written through cfg_we with no handshake and should only
// change while the block is idle.
module jog_send_interval_regulator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  jsir_pkg::item_t           item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output jsir_pkg::result_t         result,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [jsir_pkg::CFG_W-1:0] cfg_data
);
    import jsir_pkg::*;

    // Configuration
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [IVL_W-1:0] init_reg, init_next;

    // Sequencer and item state
    state_t                  state_reg, state_next;
    item_t                   item_reg, item_next;
    logic signed [POS_W-1:0] start_x_reg, start_x_next;
    logic signed [POS_W-1:0] start_y_reg, start_y_next;
    logic signed [POS_W-1:0] start_z_reg, start_z_next;

    // Error history
    logic signed [ERR_W-1:0] hist_reg [HISTORY_DEPTH];
    logic                    hist_we;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    full;

    // Datapath registers
    logic [D2_W-1:0]          d2_reg, d2_next;
    logic signed [T_W-1:0]    t_reg, t_next;
    logic signed [ERR_W-1:0]  e2_reg, e2_next;
    logic signed [SUM5_W-1:0] sum5_reg, sum5_next;
    logic [CS_W-1:0]          cs_reg, cs_next;
    logic                     fine_up_reg, fine_up_next;
    logic                     fine_dn_reg, fine_dn_next;
    logic                     coarse_up_reg, coarse_up_next;
    logic                     coarse_dn_reg, coarse_dn_next;
    logic [IVL_W-1:0]         new_ivl_reg, new_ivl_next;
    logic [IVL_W-1:0]         ivl_now_reg, ivl_now_next;

    // Output register
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    // Serial units
    logic              mul_start;
    logic [MUL_W-1:0]  mag_x, mag_y, mag_z;
    logic [MUL_W-1:0]  sent_op, seg_op;
    logic              done_x, done_y, done_z, done_s;
    logic [PROD_W-1:0] prod_x, prod_y, prod_z, prod_s;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [ROOT_W-1:0] root;

    // Comparison helpers
    logic signed [SUM5_W-1:0] sum_w;
    logic signed [SUM5_W-1:0] cs_w;
    logic signed [SUM5_W-1:0] cs2_w;
    logic signed [SUM5_W-1:0] sum_old_w;
    logic signed [IVL_W+1:0]  ivl_s;
    logic [SEG_W+2:0]         seg5;

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] p,
                                                  input logic signed [POS_W-1:0] s);
        logic signed [POS_W:0] d;
        d = {p[POS_W-1], p} - {s[POS_W-1], s};
        return d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

    function automatic logic [IVL_W-1:0] clamp_ivl(input logic signed [IVL_W+1:0] v);
        logic [IVL_W-1:0] r;
        if (v < $signed({2'b00, IVL_MIN}))
        begin
            r = IVL_MIN;
        end
        else if (v > $signed({2'b00, IVL_MAX}))
        begin
            r = IVL_MAX;
        end
        else
        begin
            r = v[IVL_W-1:0];
        end
        return r;
    endfunction

    assign mag_x   = abs_diff(item_reg.pos_x, start_x_reg);
    assign mag_y   = abs_diff(item_reg.pos_y, start_y_reg);
    assign mag_z   = abs_diff(item_reg.pos_z, start_z_reg);
    assign sent_op = {{(MUL_W-SEG_W){1'b0}}, item_reg.sent_count};
    assign seg_op  = {{(MUL_W-SEG_W){1'b0}}, seg_reg};

    jsir_mul u_mul_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag_x),
        .b     (mag_x),
        .done  (done_x),
        .prod  (prod_x)
    );

    jsir_mul u_mul_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag_y),
        .b     (mag_y),
        .done  (done_y),
        .prod  (prod_y)
    );

    jsir_mul u_mul_z (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag_z),
        .b     (mag_z),
        .done  (done_z),
        .prod  (prod_z)
    );

    // sent segments times segment distance
    jsir_mul u_mul_s (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (sent_op),
        .b     (seg_op),
        .done  (done_s),
        .prod  (prod_s)
    );

    jsir_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (d2_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    assign full      = (fill_reg == FILL_W'(HISTORY_DEPTH));
    assign seg5      = {1'b0, seg_reg, 2'b00} + {3'b000, seg_reg};
    assign sum_w     = SUM5_W'(sum_reg);
    assign cs_w      = $signed({{(SUM5_W-CS_W){1'b0}}, cs_reg});
    assign cs2_w     = cs_w <<< 1;
    assign sum_old_w = SUM5_W'(hist_reg[slot_reg]);

    always_comb
    begin
        seg_next          = seg_reg;
        init_next         = init_reg;
        state_next        = state_reg;
        item_next         = item_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        start_z_next      = start_z_reg;
        slot_next         = slot_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        hist_we           = 1'b0;
        d2_next           = d2_reg;
        t_next            = t_reg;
        e2_next           = e2_reg;
        sum5_next         = sum5_reg;
        cs_next           = cs_reg;
        fine_up_next      = fine_up_reg;
        fine_dn_next      = fine_dn_reg;
        coarse_up_next    = coarse_up_reg;
        coarse_dn_next    = coarse_dn_reg;
        new_ivl_next      = new_ivl_reg;
        ivl_now_next      = ivl_now_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        mul_start         = 1'b0;
        sqrt_start        = 1'b0;
        ivl_s             = $signed({2'b00, ivl_now_reg});

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SEGMENT_DISTANCE: seg_next  = cfg_data[SEG_W-1:0];
                REG_INITIAL_INTERVAL: init_next = cfg_data[IVL_W-1:0];
                default:              ;
            endcase
        end

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    if (item.kind == KIND_START)
                    begin
                        start_x_next = item.pos_x;
                        start_y_next = item.pos_y;
                        start_z_next = item.pos_z;
                        slot_next    = '0;
                        fill_next    = '0;
                        sum_next     = '0;
                        new_ivl_next = clamp_ivl($signed({2'b00, init_reg}));
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (done_x && done_y && done_z && done_s)
                begin
                    state_next = ST_ADD1;
                end
            end
            ST_ADD1:
            begin
                d2_next    = D2_W'(prod_x) + D2_W'(prod_y);
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                d2_next    = d2_reg + D2_W'(prod_z);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_ERR1;
                end
            end
            ST_ERR1:
            begin
                // sent*seg - real
                t_next     = $signed({2'b00, prod_s[2*SEG_W-1:0]})
                           - $signed({{(T_W-ROOT_W){1'b0}}, root});
                state_next = ST_ERR2;
            end
            ST_ERR2:
            begin
                // error in half units: 2*(sent*seg - real) - 5*seg
                e2_next    = (ERR_W'(t_reg) <<< 1)
                           - $signed({{(ERR_W-SEG_W-3){1'b0}}, seg5});
                state_next = ST_HIST1;
            end
            ST_HIST1:
            begin
                // drop the oldest error once the window is full
                if (full)
                begin
                    sum_next = sum_reg - SUM_W'(sum_old_w);
                end
                state_next = ST_HIST2;
            end
            ST_HIST2:
            begin
                hist_we   = 1'b1;
                sum_next  = sum_reg + SUM_W'(e2_reg);
                slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (!full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                sum5_next  = (sum_w <<< 2) + sum_w;
                cs_next    = CS_W'(fill_reg) * CS_W'(seg_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                fine_up_next   = sum5_reg > cs_w;
                fine_dn_next   = sum5_reg < -cs_w;
                coarse_up_next = sum_w > cs2_w;
                coarse_dn_next = sum_w < -cs2_w;
                state_next     = ST_DEC;
            end
            ST_DEC:
            begin
                if (fine_up_reg)
                begin
                    ivl_s = ivl_s + 10'sd1;
                end
                else if (fine_dn_reg)
                begin
                    ivl_s = ivl_s - 10'sd1;
                end
                if (coarse_up_reg)
                begin
                    ivl_s = ivl_s + 10'sd2;
                end
                else if (coarse_dn_reg)
                begin
                    ivl_s = ivl_s - 10'sd2;
                end
                new_ivl_next = clamp_ivl(ivl_s);
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for a free output register
                if (!result_valid_reg || result_ready)
                begin
                    result_next.send_interval    = new_ivl_reg;
                    result_next.interval_changed = (new_ivl_reg != ivl_now_reg);
                    result_valid_next            = 1'b1;
                    ivl_now_next                 = new_ivl_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg          <= SEG_RESET;
            init_reg         <= IVL_RESET;
            state_reg        <= ST_IDLE;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            start_z_reg      <= '0;
            slot_reg         <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            ivl_now_reg      <= IVL_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg          <= seg_next;
            init_reg         <= init_next;
            state_reg        <= state_next;
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            start_z_reg      <= start_z_next;
            slot_reg         <= slot_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            ivl_now_reg      <= ivl_now_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        d2_reg        <= d2_next;
        t_reg         <= t_next;
        e2_reg        <= e2_next;
        sum5_reg      <= sum5_next;
        cs_reg        <= cs_next;
        fine_up_reg   <= fine_up_next;
        fine_dn_reg   <= fine_dn_next;
        coarse_up_reg <= coarse_up_next;
        coarse_dn_reg <= coarse_dn_next;
        new_ivl_reg   <= new_ivl_next;
        result_reg    <= result_next;
        if (hist_we)
        begin
            hist_reg[slot_reg] <= e2_reg;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
